[rtl/ftsp_pkg.sv]
package ftsp_pkg;

   localparam int MaxSectors  = 32;
   localparam int SecIdxWidth = $clog2(MaxSectors);

   localparam logic [7:0] MARK_ID      = 8'hfe;
   localparam logic [7:0] MARK_DATA    = 8'hfb;
   localparam logic [7:0] MARK_DELETED = 8'hf8;
   localparam logic [7:0] TOKEN_CRC    = 8'hf7;
   localparam logic [7:0] MAX_SIZE_CODE = 8'd3;
   localparam logic [10:0] BASE_SIZE   = 11'd128;

   localparam logic CMD_START = 1'b0;

   localparam logic [2:0] REG_TRACK_NUMBER   = 3'd0;
   localparam logic [2:0] REG_SIDE_NUMBER    = 3'd1;
   localparam logic [2:0] REG_SEC_PER_TRK    = 3'd2;
   localparam logic [2:0] REG_SIZE_CODE      = 3'd3;
   localparam logic [2:0] REG_CYLINDER_COUNT = 3'd4;
   localparam logic [2:0] REG_SIDE_COUNT     = 3'd5;
   localparam logic [2:0] REG_WR_PROTECT     = 3'd6;

   typedef enum logic [2:0] {
      EV_CONSUMED  = 3'd0,
      EV_DATA      = 3'd1,
      EV_COMMIT    = 3'd2,
      EV_DONE      = 3'd3,
      EV_NOT_FOUND = 3'd4,
      EV_PROTECTED = 3'd5,
      EV_INACTIVE  = 3'd6,
      EV_STARTED   = 3'd7
   } event_type;

   typedef struct packed {
      logic [7:0] track_number;
      logic       side_number;
      logic [5:0] sec_per_trk;
      logic [1:0] size_code;
      logic [7:0] cylinder_count;
      logic [1:0] side_count;
      logic       wr_protect;
   } cfg_type;

   typedef struct packed {
      event_type  event_res;
      logic [5:0] sector_number;
      logic [9:0] byte_offset;
      logic [7:0] byte_value;
   } rsp_type;

endpackage

[rtl/ftsp_csr.sv]
module ftsp_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_data,
   output ftsp_pkg::cfg_type  cfg
);
   import ftsp_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.track_number   <= 8'd0;
         cfg_ff.side_number    <= 1'b0;
         cfg_ff.sec_per_trk    <= 6'd9;
         cfg_ff.size_code      <= 2'd2;
         cfg_ff.cylinder_count <= 8'd80;
         cfg_ff.side_count     <= 2'd2;
         cfg_ff.wr_protect     <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_TRACK_NUMBER:   cfg_ff.track_number   <= csr_data;
            REG_SIDE_NUMBER:    cfg_ff.side_number    <= csr_data[0];
            REG_SEC_PER_TRK:    cfg_ff.sec_per_trk    <= csr_data[5:0];
            REG_SIZE_CODE:      cfg_ff.size_code      <= csr_data[1:0];
            REG_CYLINDER_COUNT: cfg_ff.cylinder_count <= csr_data;
            REG_SIDE_COUNT:     cfg_ff.side_count     <= csr_data[1:0];
            REG_WR_PROTECT:     cfg_ff.wr_protect     <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/ftsp_parser.sv]
module ftsp_parser (
   input  logic               clock,
   input  logic               reset,
   input  ftsp_pkg::cfg_type  cfg,
   input  logic               step,
   input  logic               cmd,
   input  logic [7:0]         data_byte,
   output ftsp_pkg::rsp_type  rsp
);
   import ftsp_pkg::*;

   typedef enum logic [2:0] {
      PH_SEARCH_ID   = 3'd0,
      PH_ID          = 3'd1,
      PH_SEARCH_DATA = 3'd2,
      PH_DATA        = 3'd3,
      PH_CRC         = 3'd4
   } phase_type;

   logic                  active_ff, active_in;
   phase_type             phase_ff, phase_in;
   logic [1:0]            id_index_ff, id_index_in;
   logic [3:0][7:0]       id_bytes_ff, id_bytes_in;
   logic [10:0]           data_count_ff, data_count_in;
   logic [MaxSectors-1:0] seen_map_ff, seen_map_in;
   logic [5:0]            done_count_ff, done_count_in;
   rsp_type               rsp_in;

   logic [5:0]             limit;
   logic [10:0]            geo_size;
   logic                   id_ok;
   logic [SecIdxWidth-1:0] sec_idx;
   logic [MaxSectors-1:0]  sec_bit;
   logic [5:0]             done_next;

   always_comb begin
      limit = (cfg.sec_per_trk > 6'(MaxSectors)) ? 6'(MaxSectors)
                                                 : cfg.sec_per_trk;
      geo_size = BASE_SIZE << cfg.size_code;
      id_ok = (id_bytes_ff[0] == cfg.track_number)
           && (id_bytes_ff[1] == {7'd0, cfg.side_number})
           && (id_bytes_ff[2] != 8'd0)
           && (id_bytes_ff[2] <= {2'd0, limit})
           && (id_bytes_ff[3] <= MAX_SIZE_CODE)
           && (id_bytes_ff[3][1:0] == cfg.size_code);
      sec_idx = SecIdxWidth'(id_bytes_ff[2] - 8'd1);
      sec_bit = MaxSectors'(1) << sec_idx;
      done_next = done_count_ff + 6'd1;
   end

   always_comb begin
      active_in     = active_ff;
      phase_in      = phase_ff;
      id_index_in   = id_index_ff;
      id_bytes_in   = id_bytes_ff;
      data_count_in = data_count_ff;
      seen_map_in   = seen_map_ff;
      done_count_in = done_count_ff;
      rsp_in        = '{event_res: EV_CONSUMED, sector_number: 6'd0,
                        byte_offset: 10'd0, byte_value: 8'd0};
      if (cmd == CMD_START) begin
         if (cfg.wr_protect) begin
            active_in        = 1'b0;
            rsp_in.event_res = EV_PROTECTED;
         end else if (cfg.track_number >= cfg.cylinder_count
                      || {1'b0, cfg.side_number} >= cfg.side_count) begin
            active_in        = 1'b0;
            rsp_in.event_res = EV_NOT_FOUND;
         end else begin
            active_in        = 1'b1;
            phase_in         = PH_SEARCH_ID;
            id_index_in      = 2'd0;
            data_count_in    = 11'd0;
            seen_map_in      = '0;
            done_count_in    = 6'd0;
            rsp_in.event_res = EV_STARTED;
         end
      end else if (!active_ff) begin
         rsp_in.event_res = EV_INACTIVE;
      end else begin
         case (phase_ff)
            PH_ID: begin
               id_bytes_in[id_index_ff] = data_byte;
               id_index_in = id_index_ff + 2'd1;
               if (id_index_ff == 2'd3) phase_in = PH_SEARCH_DATA;
            end
            PH_SEARCH_DATA: begin
               if (data_byte == MARK_ID) begin
                  phase_in    = PH_ID;
                  id_index_in = 2'd0;
               end else if (data_byte == MARK_DATA || data_byte == MARK_DELETED) begin
                  if (!id_ok) begin
                     active_in        = 1'b0;
                     rsp_in.event_res = EV_NOT_FOUND;
                  end else begin
                     data_count_in = 11'd0;
                     phase_in      = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               rsp_in.event_res     = EV_DATA;
               rsp_in.sector_number = id_bytes_ff[2][5:0];
               rsp_in.byte_offset   = data_count_ff[9:0];
               rsp_in.byte_value    = data_byte;
               data_count_in = data_count_ff + 11'd1;
               if (data_count_in >= geo_size) phase_in = PH_CRC;
            end
            PH_CRC: begin
               if (cfg.wr_protect || data_byte != TOKEN_CRC
                   || (seen_map_ff & sec_bit) != '0) begin
                  active_in        = 1'b0;
                  rsp_in.event_res = cfg.wr_protect ? EV_PROTECTED : EV_NOT_FOUND;
               end else begin
                  seen_map_in          = seen_map_ff | sec_bit;
                  done_count_in        = done_next;
                  phase_in             = PH_SEARCH_ID;
                  rsp_in.sector_number = id_bytes_ff[2][5:0];
                  if (done_next == limit) begin
                     active_in        = 1'b0;
                     rsp_in.event_res = EV_DONE;
                  end else begin
                     rsp_in.event_res = EV_COMMIT;
                  end
               end
            end
            default: begin
               if (data_byte == MARK_ID) begin
                  phase_in    = PH_ID;
                  id_index_in = 2'd0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         phase_ff      <= PH_SEARCH_ID;
         id_index_ff   <= 2'd0;
         id_bytes_ff   <= '0;
         data_count_ff <= 11'd0;
         seen_map_ff   <= '0;
         done_count_ff <= 6'd0;
      end else if (step) begin
         active_ff     <= active_in;
         phase_ff      <= phase_in;
         id_index_ff   <= id_index_in;
         id_bytes_ff   <= id_bytes_in;
         data_count_ff <= data_count_in;
         seen_map_ff   <= seen_map_in;
         done_count_ff <= done_count_in;
      end
   end

   assign rsp = rsp_in;

endmodule

[rtl/format_track_stream_parser.sv]
// Format-track stream parser. Each accepted item (a start command or one host
// data byte) is parsed in the cycle it is taken and gives exactly one result,
// held in a single output register; a new item is taken every cycle unless that
// register is full and the result side stalls, so one item per cycle is the
// sustained rate and the result appears in the cycle after acceptance.
// Configuration writes take effect on the next cycle and belong between items.
module format_track_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [5:0]  rsp_sector_number,
   output logic [9:0]  rsp_byte_offset,
   output logic [7:0]  rsp_byte_value,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import ftsp_pkg::*;

   cfg_type cfg;
   rsp_type rsp_in, rsp_ff;
   logic    rsp_valid_ff;
   logic    step;

   ftsp_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   ftsp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .cmd       (req_cmd),
      .data_byte (req_data_byte),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = rsp_ff.event_res;
   assign rsp_sector_number = rsp_ff.sector_number;
   assign rsp_byte_offset   = rsp_ff.byte_offset;
   assign rsp_byte_value    = rsp_ff.byte_value;

endmodule

[bench/ftsp_scoreboard_pkg.sv]
package ftsp_scoreboard_pkg;

   import ftsp_pkg::*;

   typedef enum logic [2:0] {
      HUNT_ID,
      TAKE_ID,
      HUNT_DATA,
      TAKE_DATA,
      TAKE_CRC
   } parse_phase_type;

   class format_event_scoreboard_type;

      cfg_type         cfg;
      logic            cmd_active;
      parse_phase_type parse_state;
      logic [2:0]      id_pos;
      logic [7:0]      id_buf [4];
      logic [10:0]     byte_count;
      logic [63:0]     seen_sectors;
      logic [5:0]      sectors_done;
      rsp_type         expected_events [$];
      int unsigned     mismatches;

      function new();
         cfg.track_number   = 8'd0;
         cfg.side_number    = 1'b0;
         cfg.sec_per_trk    = 6'd9;
         cfg.size_code      = 2'd2;
         cfg.cylinder_count = 8'd80;
         cfg.side_count     = 2'd2;
         cfg.wr_protect     = 1'b0;
         cmd_active   = 1'b0;
         parse_state  = HUNT_ID;
         id_pos       = 3'd0;
         foreach (id_buf[i]) id_buf[i] = 8'd0;
         byte_count   = 11'd0;
         seen_sectors = '0;
         sectors_done = 6'd0;
         mismatches   = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [7:0] value);
         case (idx)
            REG_TRACK_NUMBER:   cfg.track_number   = value;
            REG_SIDE_NUMBER:    cfg.side_number    = value[0];
            REG_SEC_PER_TRK:    cfg.sec_per_trk    = value[5:0];
            REG_SIZE_CODE:      cfg.size_code      = value[1:0];
            REG_CYLINDER_COUNT: cfg.cylinder_count = value;
            REG_SIDE_COUNT:     cfg.side_count     = value[1:0];
            REG_WR_PROTECT:     cfg.wr_protect     = value[0];
            default: ;
         endcase
      endfunction

      function int unsigned sector_cap();
         if (int'(cfg.sec_per_trk) > MaxSectors) return MaxSectors;
         return 32'(cfg.sec_per_trk);
      endfunction

      function int unsigned sector_bytes();
         return 128 << cfg.size_code;
      endfunction

      function int unsigned pending();
         return expected_events.size();
      endfunction

      function void note_item(logic cmd, logic [7:0] b);
         rsp_type     r;
         int unsigned id_size;
         logic [5:0]  bit_idx;
         r = '0;
         r.event_res = EV_CONSUMED;
         if (cmd == CMD_START) begin
            if (cfg.wr_protect) begin
               cmd_active  = 1'b0;
               r.event_res = EV_PROTECTED;
            end else if (cfg.track_number >= cfg.cylinder_count ||
                         {1'b0, cfg.side_number} >= cfg.side_count) begin
               cmd_active  = 1'b0;
               r.event_res = EV_NOT_FOUND;
            end else begin
               cmd_active   = 1'b1;
               parse_state  = HUNT_ID;
               id_pos       = 3'd0;
               byte_count   = 11'd0;
               seen_sectors = '0;
               sectors_done = 6'd0;
               r.event_res  = EV_STARTED;
            end
         end else if (!cmd_active) begin
            r.event_res = EV_INACTIVE;
         end else begin
            case (parse_state)
               TAKE_ID: begin
                  id_buf[id_pos[1:0]] = b;
                  id_pos = id_pos + 3'd1;
                  if (id_pos >= 3'd4) parse_state = HUNT_DATA;
               end
               HUNT_DATA: begin
                  if (b == MARK_ID) begin
                     parse_state = TAKE_ID;
                     id_pos      = 3'd0;
                  end else if (b == MARK_DATA || b == MARK_DELETED) begin
                     id_size = (id_buf[3] <= MAX_SIZE_CODE) ? (128 << id_buf[3]) : 0;
                     if (id_buf[0] != cfg.track_number ||
                         id_buf[1] != {7'd0, cfg.side_number} ||
                         id_buf[2] == 8'd0 || id_buf[2] > sector_cap() ||
                         id_size != sector_bytes()) begin
                        cmd_active  = 1'b0;
                        r.event_res = EV_NOT_FOUND;
                     end else begin
                        byte_count  = 11'd0;
                        parse_state = TAKE_DATA;
                     end
                  end
               end
               TAKE_DATA: begin
                  r.event_res     = EV_DATA;
                  r.sector_number = id_buf[2][5:0];
                  r.byte_offset   = byte_count[9:0];
                  r.byte_value    = b;
                  byte_count = byte_count + 11'd1;
                  if (byte_count >= sector_bytes()) parse_state = TAKE_CRC;
               end
               TAKE_CRC: begin
                  bit_idx = id_buf[2][5:0] - 6'd1;
                  if (cfg.wr_protect || b != TOKEN_CRC || seen_sectors[bit_idx]) begin
                     cmd_active  = 1'b0;
                     r.event_res = cfg.wr_protect ? EV_PROTECTED : EV_NOT_FOUND;
                  end else begin
                     seen_sectors[bit_idx] = 1'b1;
                     sectors_done = sectors_done + 6'd1;
                     parse_state  = HUNT_ID;
                     r.sector_number = id_buf[2][5:0];
                     if (sectors_done == sector_cap()) begin
                        cmd_active  = 1'b0;
                        r.event_res = EV_DONE;
                     end else begin
                        r.event_res = EV_COMMIT;
                     end
                  end
               end
               default: begin
                  if (b == MARK_ID) begin
                     parse_state = TAKE_ID;
                     id_pos      = 3'd0;
                  end
               end
            endcase
         end
         expected_events = {expected_events, r};
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         $display("mismatch: %s got %0d expected %0d", what, got, want);
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_events.size() == 0) begin
            report("unexpected item, event_res", got.event_res, 0);
            return;
         end
         want = expected_events.pop_front();
         if (got.event_res != want.event_res)
            report("event_res", got.event_res, want.event_res);
         if (got.sector_number != want.sector_number)
            report("sector_number", got.sector_number, want.sector_number);
         if (got.byte_offset != want.byte_offset)
            report("byte_offset", got.byte_offset, want.byte_offset);
         if (got.byte_value != want.byte_value)
            report("byte_value", got.byte_value, want.byte_value);
      endtask

   endclass

endpackage

[bench/tb_top.sv]
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import ftsp_pkg::*;
   import ftsp_scoreboard_pkg::*;

   localparam logic CMD_DATA    = 1'b1;
   localparam int   STALL_LIMIT = 2000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_cmd = 1'b1;
   logic [7:0] req_data_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_event_res;
   logic [5:0] rsp_sector_number;
   logic [9:0] rsp_byte_offset;
   logic [7:0] rsp_byte_value;
   logic       csr_write_en = 1'b0;
   logic [2:0] csr_index = 3'd0;
   logic [7:0] csr_data = 8'd0;

   format_event_scoreboard_type sb = new();

   int unsigned req_idle_pct = 32;
   int unsigned rsp_idle_pct = 56;
   int unsigned items_sent = 0;
   int unsigned stall_cycles = 0;
   bit          hold_req = 1'b0;

   format_track_stream_parser u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_res     (rsp_event_res),
      .rsp_sector_number (rsp_sector_number),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_byte_value    (rsp_byte_value),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
      else stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("format_track_stream_parser verification failed");
         $finish;
      end
   end

   initial begin : result_sink
      int unsigned hold_left;
      rsp_type     got;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.event_res     = event_type'(rsp_event_res);
            got.sector_number = rsp_sector_number;
            got.byte_offset   = rsp_byte_offset;
            got.byte_value    = rsp_byte_value;
            sb.check_result(got);
         end
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 300;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   task automatic offer_item(input logic cmd, input logic [7:0] b);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(cmd, b);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [7:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] trk, input logic sd, input logic [5:0] spt,
                             input logic [1:0] code, input logic [7:0] cyl,
                             input logic [1:0] scnt, input logic wp);
      csr_write(REG_TRACK_NUMBER, trk);
      csr_write(REG_SIDE_NUMBER, {7'd0, sd});
      csr_write(REG_SEC_PER_TRK, {2'd0, spt});
      csr_write(REG_SIZE_CODE, {6'd0, code});
      csr_write(REG_CYLINDER_COUNT, cyl);
      csr_write(REG_SIDE_COUNT, {6'd0, scnt});
      csr_write(REG_WR_PROTECT, {7'd0, wp});
   endtask

   task automatic randomize_config();
      logic [7:0]  trk;
      logic [7:0]  cyl;
      logic        sd;
      logic [1:0]  scnt;
      logic [5:0]  spt;
      logic [1:0]  code;
      logic        wp;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      trk = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
      if ($urandom_range(0, 9) != 0 && trk != 8'd255) cyl = 8'($urandom_range(trk + 1, 255));
      else cyl = 8'($urandom);
      sd = 1'($urandom);
      if ($urandom_range(0, 9) != 0) scnt = sd ? 2'd2 : 2'($urandom_range(1, 2));
      else scnt = 2'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 80) spt = 6'($urandom_range(1, 2));
      else if (pick < 88) spt = 6'($urandom_range(3, 32));
      else if (pick < 94) spt = 6'($urandom_range(33, 63));
      else spt = 6'd0;
      pick = $urandom_range(0, 99);
      code = (pick < 90) ? 2'd0 : 2'd1;
      if (code != 2'd0) spt = 6'd1;
      wp = ($urandom_range(0, 99) < 8);
      set_config(trk, sd, spt, code, cyl, scnt, wp);
   endtask

   function automatic logic [7:0] filler_byte();
      logic [7:0] g;
      g = 8'($urandom);
      if (g == MARK_ID || g == MARK_DATA || g == MARK_DELETED) g = 8'h4e;
      return g;
   endfunction

   task automatic send_id(input logic [7:0] trk, input logic [7:0] sd,
                          input logic [7:0] sec, input logic [7:0] code);
      offer_item(CMD_DATA, MARK_ID);
      offer_item(CMD_DATA, trk);
      offer_item(CMD_DATA, sd);
      offer_item(CMD_DATA, sec);
      offer_item(CMD_DATA, code);
   endtask

   task automatic run_track(input bit clean);
      int unsigned cap;
      int unsigned nsec;
      int unsigned fault;
      int unsigned sec;
      logic [7:0]  trk;
      logic [7:0]  sd;
      logic [7:0]  code;
      logic [7:0]  crc;
      logic [63:0] used;
      cap  = sb.sector_cap();
      nsec = (cap == 0) ? 2 : ((cap < 2) ? cap : 2);
      used = '0;
      offer_item(CMD_START, 8'($urandom));
      for (int k = 0; k < nsec && sb.cmd_active; k++) begin
         fault = clean ? 99 : $urandom_range(0, 99);
         do sec = $urandom_range(1, (cap == 0) ? 32 : cap);
         while (cap != 0 && used[sec - 1]);
         trk  = sb.cfg.track_number;
         sd   = {7'd0, sb.cfg.side_number};
         code = {6'd0, sb.cfg.size_code};
         if (fault < 4) begin
            for (int i = 0; i < 32; i++) if (used[i]) sec = i + 1;
         end else if (fault < 8) begin
            trk = trk ^ 8'(1 << $urandom_range(0, 7));
         end else if (fault < 11) begin
            sd = sd ^ 8'(1 << $urandom_range(0, 7));
         end else if (fault < 14) begin
            sec = 0;
         end else if (fault < 17) begin
            sec = $urandom_range(cap + 1, 255);
         end else if (fault < 20) begin
            do code = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            while (code == {6'd0, sb.cfg.size_code});
         end else if (fault < 23) begin
            offer_item(CMD_START, 8'($urandom));
            used = '0;
         end
         repeat ($urandom_range(0, 3)) offer_item(CMD_DATA, filler_byte());
         send_id(trk, sd, 8'(sec), code);
         repeat ($urandom_range(0, 2)) offer_item(CMD_DATA, filler_byte());
         if (fault >= 23 && fault < 27) send_id(trk, sd, 8'(sec), code);
         offer_item(CMD_DATA, $urandom_range(0, 1) ? MARK_DATA : MARK_DELETED);
         if (!sb.cmd_active) break;
         repeat (sb.sector_bytes()) offer_item(CMD_DATA, 8'($urandom));
         crc = TOKEN_CRC;
         if (fault >= 27 && fault < 30) begin
            do crc = 8'($urandom);
            while (crc == TOKEN_CRC);
         end
         // protect the medium while the sector waits for its CRC token
         if (fault >= 30 && fault < 33) begin
            wait_idle();
            csr_write(REG_WR_PROTECT, 8'd1);
         end
         offer_item(CMD_DATA, crc);
         if (fault >= 30 && fault < 33) begin
            wait_idle();
            csr_write(REG_WR_PROTECT, 8'd0);
         end
         if (sec != 0) used[sec - 1] = 1'b1;
      end
   endtask

   initial begin : stimulus
      int unsigned goal;
      int unsigned tracks;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      offer_item(CMD_DATA, 8'h00);
      offer_item(CMD_DATA, 8'hff);
      wait_idle();
      csr_write(REG_WR_PROTECT, 8'd1);
      offer_item(CMD_START, 8'h00);
      wait_idle();
      csr_write(REG_WR_PROTECT, 8'd0);
      csr_write(REG_TRACK_NUMBER, 8'd80);
      offer_item(CMD_START, 8'hff);
      wait_idle();
      csr_write(REG_TRACK_NUMBER, 8'd79);
      csr_write(REG_SIDE_NUMBER, 8'd1);
      csr_write(REG_SIDE_COUNT, 8'd1);
      offer_item(CMD_START, 8'h5a);
      wait_idle();
      csr_write(REG_SIDE_COUNT, 8'd2);
      offer_item(CMD_START, 8'ha5);
      offer_item(CMD_DATA, 8'h4e);
      send_id(8'd79, 8'd1, 8'd5, 8'd2);
      send_id(8'd79, 8'd1, 8'd0, 8'd2);
      offer_item(CMD_DATA, MARK_DATA);
      offer_item(CMD_START, 8'h3c);
      send_id(8'd79, 8'd1, 8'd10, 8'd2);
      offer_item(CMD_DATA, MARK_DELETED);

      for (int p = 0; p < 3; p++) begin
         wait_idle();
         case (p)
            0: begin
               req_idle_pct = 32;
               rsp_idle_pct = 56;
               randomize_config();
            end
            1: begin
               req_idle_pct = 56;
               rsp_idle_pct = 32;
               set_config(8'd0, 1'b0, 6'd1, 2'd0, 8'd1, 2'd1, 1'b0);
               run_track(1'b1);
               wait_idle();
               randomize_config();
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
               set_config(8'd254, 1'b1, 6'd32, 2'd0, 8'd255, 2'd2, 1'b0);
               hold_req = 1'b1;
            end
         endcase
         goal   = items_sent + 60;
         tracks = 0;
         while (items_sent < goal) begin
            run_track(1'b0);
            tracks++;
            if ($urandom_range(0, 99) < 15)
               repeat ($urandom_range(1, 3)) offer_item(CMD_DATA, 8'($urandom));
            if (tracks % 3 == 0) begin
               wait_idle();
               randomize_config();
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("format_track_stream_parser verification clean");
      else
         $display("format_track_stream_parser verification failed");
      $finish;
   end

endmodule

[format_track_stream_parser.f]
rtl/ftsp_pkg.sv
rtl/ftsp_csr.sv
rtl/ftsp_parser.sv
rtl/format_track_stream_parser.sv
bench/ftsp_scoreboard_pkg.sv
bench/tb_top.sv
